// ===== hdl/pld_pkg.sv =====
package pld_pkg;

    // Default number of fraction bits in the log and exp2 chains.
    localparam int POW_ITER_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DAMPING  = 2'd0;
    localparam logic [1:0] CFG_EXPONENT = 2'd1;
    localparam logic [1:0] CFG_PROJ_X   = 2'd2;
    localparam logic [1:0] CFG_PROJ_Z   = 2'd3;

    // Data that rides along the power pipeline with each transaction.
    typedef struct packed {
        logic signed [31:0] elong;
        logic               sat;
        logic               neg;
        logic               zero;
    } side_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } clip_t;

    // Clip a wide signed value to the signed 32-bit range.
    function automatic clip_t pld_clip(input logic signed [49:0] v);
        clip_t r;
        if (v > 50'sd2147483647)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Shift right by 14 with rounding to nearest, ties away from zero.
    function automatic logic signed [49:0] pld_round14(input logic signed [49:0] v);
        logic [49:0] mag;
        logic [49:0] m;
        mag = v[49] ? 50'(-v) : 50'(v);
        m = (mag + 50'd8192) >> 14;
        return v[49] ? -$signed(m) : $signed(m);
    endfunction

    // Integer square root, used only to build constants.
    function automatic logic [63:0] pld_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x = x_in;
        res = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Q1.30 value of 2^(2^-k).
    function automatic logic [30:0] pld_root(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int j = 0; j < k; j++)
        begin
            r = pld_isqrt(r << 30);
        end
        return r[30:0];
    endfunction

endpackage

// ===== hdl/pld_front.sv =====
module pld_front
    import pld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] disp_i_x,
    input  logic signed [31:0] disp_i_z,
    input  logic signed [31:0] disp_j_x,
    input  logic signed [31:0] disp_j_z,
    input  logic signed [31:0] vel_i_x,
    input  logic signed [31:0] vel_i_z,
    input  logic signed [31:0] vel_j_x,
    input  logic signed [31:0] vel_j_z,
    input  logic signed [15:0] proj_x,
    input  logic signed [15:0] proj_z,
    output logic               out_valid,
    output logic [30:0]        y,
    output logic [5:0]         msb,
    output side_t              side
);

    logic [5:0] valid_reg;

    logic signed [32:0] du_x_reg, du_z_reg, dv_x_reg, dv_z_reg;
    logic signed [48:0] pu_x_reg, pu_z_reg, pv_x_reg, pv_z_reg;
    logic signed [49:0] ue_reg, ve_reg;
    logic [36:0]        vm_reg, vm5_reg;
    side_t              side4_reg, side5_reg, side6_reg;
    logic [5:0]         msb_reg, msb6_reg;
    logic [30:0]        y_reg;

    logic [36:0] vm_next;
    logic [49:0] vmag;
    logic [50:0] vsum;
    clip_t       el_clip;
    logic [5:0]  msb_next;
    logic [66:0] norm;

    // Valid bits advance every cycle; the receiver never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    // Stage 1: node differences.
    always_ff @(posedge clk)
    begin
        du_x_reg <= 33'(disp_j_x) - 33'(disp_i_x);
        du_z_reg <= 33'(disp_j_z) - 33'(disp_i_z);
        dv_x_reg <= 33'(vel_j_x) - 33'(vel_i_x);
        dv_z_reg <= 33'(vel_j_z) - 33'(vel_i_z);
    end

    // Stage 2: products with the direction cosines.
    always_ff @(posedge clk)
    begin
        pu_x_reg <= 49'(proj_x) * 49'(du_x_reg);
        pu_z_reg <= 49'(proj_z) * 49'(du_z_reg);
        pv_x_reg <= 49'(proj_x) * 49'(dv_x_reg);
        pv_z_reg <= 49'(proj_z) * 49'(dv_z_reg);
    end

    // Stage 3: projected sums.
    always_ff @(posedge clk)
    begin
        ue_reg <= 50'(pu_x_reg) + 50'(pu_z_reg);
        ve_reg <= 50'(pv_x_reg) + 50'(pv_z_reg);
    end

    // Stage 4: elongation rounding and the rounded rate magnitude.
    always_comb
    begin
        el_clip = pld_clip(pld_round14(ue_reg));
        vmag = ve_reg[49] ? 50'(-ve_reg) : 50'(ve_reg);
        vsum = 51'(vmag) + 51'd8192;
        vm_next = vsum[50:14];
    end

    always_ff @(posedge clk)
    begin
        vm_reg <= vm_next;
        side4_reg.elong <= el_clip.val;
        side4_reg.sat <= el_clip.sat;
        side4_reg.neg <= ve_reg[49];
        side4_reg.zero <= 1'b0;
    end

    // Stage 5: leading-one position of the rate magnitude.
    always_comb
    begin
        msb_next = 6'd0;
        for (int b = 0; b < 37; b++)
        begin
            if (vm_reg[b])
                msb_next = 6'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        vm5_reg <= vm_reg;
        msb_reg <= msb_next;
        side5_reg.elong <= side4_reg.elong;
        side5_reg.sat <= side4_reg.sat;
        side5_reg.neg <= side4_reg.neg;
        side5_reg.zero <= (vm_reg == 37'd0);
    end

    // Stage 6: normalize the mantissa to Q1.30.
    assign norm = {vm5_reg, 30'd0} >> msb_reg;

    always_ff @(posedge clk)
    begin
        y_reg <= norm[30:0];
        msb6_reg <= msb_reg;
        side6_reg <= side5_reg;
    end

    assign out_valid = valid_reg[5];
    assign y = y_reg;
    assign msb = msb6_reg;
    assign side = side6_reg;

endmodule

// ===== hdl/pld_log.sv =====
module pld_log
    import pld_pkg::*;
#(
    parameter int POW_ITERATIONS = POW_ITER_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [30:0]                       y,
    input  logic [5:0]                        msb,
    input  side_t                             side_in,
    output logic                              out_valid,
    output logic signed [POW_ITERATIONS+6:0]  logv,
    output side_t                             side_out
);

    localparam int P = POW_ITERATIONS;

    logic          valid_reg [P];
    logic [30:0]   y_reg     [P];
    logic [P-1:0]  frac_reg  [P];
    logic [5:0]    msb_reg   [P];
    side_t         side_reg  [P];

    logic signed [6:0] exp_int;

    // One squaring of the mantissa per stage yields one fraction bit.
    for (genvar k = 0; k < P; k++)
    begin : g_sq
        logic          v_in;
        logic [30:0]   y_in;
        logic [P-1:0]  f_in;
        logic [5:0]    m_in;
        side_t         s_in;
        logic [61:0]   sq;
        logic [31:0]   t;
        logic [30:0]   y_next;
        logic [P-1:0]  frac_next;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign y_in = y;
            assign f_in = '0;
            assign m_in = msb;
            assign s_in = side_in;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[k-1];
            assign y_in = y_reg[k-1];
            assign f_in = frac_reg[k-1];
            assign m_in = msb_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            sq = 62'(y_in) * 62'(y_in);
            t = sq[61:30];
            y_next = t[31] ? t[31:1] : t[30:0];
            frac_next = {f_in[P-2:0], t[31]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            y_reg[k] <= y_next;
            frac_reg[k] <= frac_next;
            msb_reg[k] <= m_in;
            side_reg[k] <= s_in;
        end
    end

    // Integer part of the log from the leading-one position.
    assign exp_int = $signed({1'b0, msb_reg[P-1]}) - 7'sd16;

    assign out_valid = valid_reg[P-1];
    assign logv = $signed({exp_int, frac_reg[P-1]});
    assign side_out = side_reg[P-1];

endmodule

// ===== hdl/pld_exp2.sv =====
module pld_exp2
    import pld_pkg::*;
#(
    parameter int POW_ITERATIONS = POW_ITER_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [POW_ITERATIONS+6:0]  logv,
    input  side_t                             side_in,
    input  logic [15:0]                       exponent,
    output logic                              out_valid,
    output logic [30:0]                       acc,
    output logic signed [9:0]                 n_out,
    output side_t                             side_out
);

    localparam int P  = POW_ITERATIONS;
    localparam int PW = P + 24;

    logic signed [PW-1:0] p;
    logic                 valid0_reg;
    logic signed [9:0]    n0_reg;
    logic [P-1:0]         ff0_reg;
    side_t                side0_reg;

    logic                 valid_reg [P];
    logic [30:0]          acc_reg   [P];
    logic signed [9:0]    n_reg     [P];
    logic [P-1:0]         ff_reg    [P];
    side_t                side_reg  [P];

    // Scale the log by alpha; floor integer and fraction fall out of the bits.
    assign p = PW'(logv) * PW'($signed({1'b0, exponent}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else
            valid0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        n0_reg <= p[PW-1:P+14];
        ff0_reg <= p[P+13:14];
        side0_reg <= side_in;
    end

    // One root product per stage, for the fraction bits from the top down.
    for (genvar k = 0; k < P; k++)
    begin : g_root
        localparam logic [30:0] ROOT = pld_root(k + 1);

        logic              v_in;
        logic [30:0]       a_in;
        logic signed [9:0] n_in;
        logic [P-1:0]      f_in;
        side_t             s_in;
        logic [61:0]       prod;
        logic [30:0]       acc_next;

        if (k == 0)
        begin : g_first
            assign v_in = valid0_reg;
            assign a_in = 31'h40000000;
            assign n_in = n0_reg;
            assign f_in = ff0_reg;
            assign s_in = side0_reg;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[k-1];
            assign a_in = acc_reg[k-1];
            assign n_in = n_reg[k-1];
            assign f_in = ff_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            prod = 62'(a_in) * 62'(ROOT);
            acc_next = f_in[P-1-k] ? prod[60:30] : a_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            acc_reg[k] <= acc_next;
            n_reg[k] <= n_in;
            ff_reg[k] <= f_in;
            side_reg[k] <= s_in;
        end
    end

    assign out_valid = valid_reg[P-1];
    assign acc = acc_reg[P-1];
    assign n_out = n_reg[P-1];
    assign side_out = side_reg[P-1];

endmodule

// ===== hdl/pld_back.sv =====
module pld_back
    import pld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [30:0]        acc,
    input  logic signed [9:0]  n_in,
    input  side_t              side_in,
    input  logic [31:0]        damping_coeff,
    input  logic signed [15:0] proj_x,
    input  logic signed [15:0] proj_z,
    output logic               done,
    output logic signed [31:0] elongation,
    output logic signed [31:0] axial_force,
    output logic signed [31:0] force_i_x,
    output logic signed [31:0] force_i_z,
    output logic signed [31:0] force_j_x,
    output logic signed [31:0] force_j_z,
    output logic               saturated
);

    logic [4:0] valid_reg;

    logic [62:0]        prod_reg;
    logic signed [9:0]  n_reg;
    side_t              side1_reg, side2_reg, side3_reg, side4_reg;
    logic [33:0]        fm_reg;
    logic signed [31:0] f_reg, f4_reg;
    logic signed [47:0] q_x_reg, q_z_reg;

    logic signed [31:0] elong_reg, axial_reg;
    logic signed [31:0] fix_reg, fiz_reg, fjx_reg, fjz_reg;
    logic               sat_reg, zero_reg, neg_reg;

    logic signed [10:0] sh;
    logic signed [10:0] kk;
    logic [63:0]        shr;
    logic [63:0]        lim;
    logic [63:0]        shl;
    logic [33:0]        fm_next;
    clip_t              f_clip;
    logic signed [49:0] f_wide;
    logic signed [49:0] r_x, r_z;
    clip_t              c_ix, c_iz, c_jx, c_jz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    // Stage 1: damping coefficient times 2^fraction.
    always_ff @(posedge clk)
    begin
        prod_reg <= 63'(damping_coeff) * 63'(acc);
        n_reg <= n_in;
        side1_reg <= side_in;
    end

    // Stage 2: apply 2^n with the overflow clamp at 2^33.
    always_comb
    begin
        sh = 11'sd30 - 11'(n_reg);
        kk = -sh;
        shr = 64'(prod_reg) >> sh[5:0];
        lim = (64'd1 << 33) >> kk[4:0];
        shl = 64'(prod_reg) << kk[4:0];
        if (side1_reg.zero)
            fm_next = 34'd0;
        else if (!sh[10])
        begin
            if (sh >= 11'sd64)
                fm_next = 34'd0;
            else if (shr > (64'd1 << 33))
                fm_next = 34'h200000000;
            else
                fm_next = shr[33:0];
        end
        else if (prod_reg == 63'd0)
            fm_next = 34'd0;
        else if (kk >= 11'sd32 || 64'(prod_reg) > lim)
            fm_next = 34'h200000000;
        else
            fm_next = shl[33:0];
    end

    always_ff @(posedge clk)
    begin
        fm_reg <= fm_next;
        side2_reg <= side1_reg;
    end

    // Stage 3: apply the sign of the rate and clip.
    always_comb
    begin
        f_wide = side2_reg.neg ? -$signed(50'(fm_reg)) : $signed(50'(fm_reg));
        f_clip = pld_clip(f_wide);
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_clip.val;
        side3_reg.elong <= side2_reg.elong;
        side3_reg.sat <= side2_reg.sat | f_clip.sat;
        side3_reg.neg <= side2_reg.neg;
        side3_reg.zero <= side2_reg.zero;
    end

    // Stage 4: nodal force products.
    always_ff @(posedge clk)
    begin
        q_x_reg <= 48'(proj_x) * 48'(f_reg);
        q_z_reg <= 48'(proj_z) * 48'(f_reg);
        f4_reg <= f_reg;
        side4_reg <= side3_reg;
    end

    // Stage 5: rounding and clipping; node I takes the negated share.
    always_comb
    begin
        r_x = pld_round14(50'(q_x_reg));
        r_z = pld_round14(50'(q_z_reg));
        c_jx = pld_clip(r_x);
        c_jz = pld_clip(r_z);
        c_ix = pld_clip(-r_x);
        c_iz = pld_clip(-r_z);
    end

    always_ff @(posedge clk)
    begin
        elong_reg <= side4_reg.elong;
        axial_reg <= f4_reg;
        fix_reg <= c_ix.val;
        fiz_reg <= c_iz.val;
        fjx_reg <= c_jx.val;
        fjz_reg <= c_jz.val;
        sat_reg <= side4_reg.sat | c_ix.sat | c_iz.sat | c_jx.sat | c_jz.sat;
        zero_reg <= side4_reg.zero;
        neg_reg <= side4_reg.neg;
    end

    assign done = valid_reg[4];
    assign elongation = elong_reg;
    assign axial_force = axial_reg;
    assign force_i_x = fix_reg;
    assign force_i_z = fiz_reg;
    assign force_j_x = fjx_reg;
    assign force_j_z = fjz_reg;
    assign saturated = sat_reg;

    // A zero rate yields zero force at every node.
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_reg |-> axial_force == 32'sd0 && force_j_x == 32'sd0
            && force_j_z == 32'sd0 && force_i_x == 32'sd0 && force_i_z == 32'sd0)
        else $error("zero rate gave a nonzero force");

    // Without clipping the two nodes carry opposite forces.
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        done && !saturated |-> force_i_x == -force_j_x && force_i_z == -force_j_z)
        else $error("nodal forces out of balance");

    // The force follows the sign of the elongation rate.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && axial_force != 32'sd0 |-> axial_force[31] == neg_reg)
        else $error("force sign disagrees with rate sign");

endmodule

// ===== hdl/power_law_dashpot_force_core.sv =====
// Power-law dashpot force core. A transaction is accepted on every cycle in
// which start is high; busy never rises, so one element enters per clock.
// Each result passes the front, log, exp2 and back pipelines in turn and is
// held for one cycle with done high; the receiver cannot stall and must
// take it then. The pipeline holds two chains of POW_ITERATIONS stages:
// the mantissa squarings that build log2 of the rate, and the root products
// that build 2^fraction, each one 31x31 multiply per stage. Configuration
// may be written only while no transaction is in flight.
module power_law_dashpot_force_core
    import pld_pkg::*;
#(
    parameter int POW_ITERATIONS = POW_ITER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] disp_i_x,
    input  logic signed [31:0] disp_i_z,
    input  logic signed [31:0] disp_j_x,
    input  logic signed [31:0] disp_j_z,
    input  logic signed [31:0] vel_i_x,
    input  logic signed [31:0] vel_i_z,
    input  logic signed [31:0] vel_j_x,
    input  logic signed [31:0] vel_j_z,
    output logic               done,
    output logic signed [31:0] elongation,
    output logic signed [31:0] axial_force,
    output logic signed [31:0] force_i_x,
    output logic signed [31:0] force_i_z,
    output logic signed [31:0] force_j_x,
    output logic signed [31:0] force_j_z,
    output logic               saturated
);

    logic [31:0]        damping_reg;
    logic [15:0]        exponent_reg;
    logic signed [15:0] proj_x_reg;
    logic signed [15:0] proj_z_reg;

    logic                                    fr_valid;
    logic [30:0]                             fr_y;
    logic [5:0]                              fr_msb;
    side_t                                   fr_side;
    logic                                    lg_valid;
    logic signed [POW_ITERATIONS+6:0]        lg_logv;
    side_t                                   lg_side;
    logic                                    ex_valid;
    logic [30:0]                             ex_acc;
    logic signed [9:0]                       ex_n;
    side_t                                   ex_side;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= 32'd0;
            exponent_reg <= 16'd16384;
            proj_x_reg <= 16'sd16384;
            proj_z_reg <= 16'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DAMPING:  damping_reg <= cfg_data;
                CFG_EXPONENT: exponent_reg <= cfg_data[15:0];
                CFG_PROJ_X:   proj_x_reg <= cfg_data[15:0];
                CFG_PROJ_Z:   proj_z_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances every cycle.
    assign busy = 1'b0;

    pld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .disp_i_x  (disp_i_x),
        .disp_i_z  (disp_i_z),
        .disp_j_x  (disp_j_x),
        .disp_j_z  (disp_j_z),
        .vel_i_x   (vel_i_x),
        .vel_i_z   (vel_i_z),
        .vel_j_x   (vel_j_x),
        .vel_j_z   (vel_j_z),
        .proj_x    (proj_x_reg),
        .proj_z    (proj_z_reg),
        .out_valid (fr_valid),
        .y         (fr_y),
        .msb       (fr_msb),
        .side      (fr_side)
    );

    pld_log #(.POW_ITERATIONS(POW_ITERATIONS)) u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .y         (fr_y),
        .msb       (fr_msb),
        .side_in   (fr_side),
        .out_valid (lg_valid),
        .logv      (lg_logv),
        .side_out  (lg_side)
    );

    pld_exp2 #(.POW_ITERATIONS(POW_ITERATIONS)) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lg_valid),
        .logv      (lg_logv),
        .side_in   (lg_side),
        .exponent  (exponent_reg),
        .out_valid (ex_valid),
        .acc       (ex_acc),
        .n_out     (ex_n),
        .side_out  (ex_side)
    );

    pld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (ex_valid),
        .acc           (ex_acc),
        .n_in          (ex_n),
        .side_in       (ex_side),
        .damping_coeff (damping_reg),
        .proj_x        (proj_x_reg),
        .proj_z        (proj_z_reg),
        .done          (done),
        .elongation    (elongation),
        .axial_force   (axial_force),
        .force_i_x     (force_i_x),
        .force_i_z     (force_i_z),
        .force_j_x     (force_j_x),
        .force_j_z     (force_j_z),
        .saturated     (saturated)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pld_pkg::*;

    localparam int POW_N = POW_ITER_DEF;
    localparam int LATENCY = 2 * POW_N + 12;

    // One element evaluation: node displacements and velocities.
    typedef struct {
        logic signed [31:0] ux_i;
        logic signed [31:0] uz_i;
        logic signed [31:0] ux_j;
        logic signed [31:0] uz_j;
        logic signed [31:0] vx_i;
        logic signed [31:0] vz_i;
        logic signed [31:0] vx_j;
        logic signed [31:0] vz_j;
    } element_t;

    // Expected dashpot response for one element.
    typedef struct {
        logic signed [31:0] elong;
        logic signed [31:0] fax;
        logic signed [31:0] f_ix;
        logic signed [31:0] f_iz;
        logic signed [31:0] f_jx;
        logic signed [31:0] f_jz;
        logic               sat;
    } response_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic signed [31:0] disp_i_x, disp_i_z, disp_j_x, disp_j_z;
    logic signed [31:0] vel_i_x, vel_i_z, vel_j_x, vel_j_z;
    logic done;
    logic signed [31:0] elongation, axial_force;
    logic signed [31:0] force_i_x, force_i_z, force_j_x, force_j_z;
    logic saturated;

    // Predictor copy of the registers.
    logic [31:0] coef_c;
    logic [15:0] coef_alpha;
    logic signed [15:0] cos_x;
    logic signed [15:0] cos_z;

    element_t pending_elements[$];
    response_t expected_responses[$];
    int idle_pct;
    bit hold_off;
    int error_count;
    int response_count;
    int element_count;
    int sat_count;
    int zero_rate_count;

    power_law_dashpot_force_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout after %0d responses", response_count);
        $display("power_law_dashpot_force_core: mismatch");
        $finish;
    end

    function automatic longint mag64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint rnd_shift14(input longint v);
        longint m;
        m = (mag64(v) + 64'sd8192) >>> 14;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint sat32(input longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x = x_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // c * m^alpha via log2 by mantissa squaring and exp2 by chained roots.
    function automatic logic [63:0] damper_power(input logic [63:0] m);
        int msb;
        logic [63:0] y, frac, ff, acc, root, prod;
        longint logv, p, n, r, sh, den;
        msb = 63;
        frac = 0;
        den = 64'sd1 <<< (POW_N + 14);
        while (m[msb] == 1'b0)
            msb--;
        if (msb >= 30)
            y = m >> (msb - 30);
        else
            y = m << (30 - msb);
        for (int i = 0; i < POW_N; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                frac[0] = 1'b1;
                y = y >> 1;
            end
        end
        logv = longint'(msb - 16) * (64'sd1 <<< POW_N) + longint'(frac);
        p = logv * longint'({16'd0, coef_alpha});
        n = p / den;
        r = p - n * den;
        if (r < 0)
        begin
            n--;
            r += den;
        end
        ff = r >> 14;
        acc = 64'd1 << 30;
        root = 64'd2 << 30;
        for (int i = 1; i <= POW_N; i++)
        begin
            root = int_sqrt(root << 30);
            if (ff[POW_N - i])
                acc = (acc * root) >> 30;
        end
        prod = {32'd0, coef_c} * acc;
        sh = 30 - n;
        if (sh >= 0)
            return sh >= 64 ? 64'd0 : prod >> sh;
        if (prod == 0)
            return 0;
        if (-sh >= 32 || prod > ((64'd1 << 33) >> -sh))
            return 64'd1 << 33;
        return prod << -sh;
    endfunction

    function automatic response_t dashpot_response(input element_t e);
        response_t o;
        bit sat;
        longint px, pz, ue, ve, f, vm;
        logic [63:0] fm;
        sat = 1'b0;
        px = cos_x;
        pz = cos_z;
        ue = px * (longint'(e.ux_j) - e.ux_i) + pz * (longint'(e.uz_j) - e.uz_i);
        ve = px * (longint'(e.vx_j) - e.vx_i) + pz * (longint'(e.vz_j) - e.vz_i);
        o.elong = 32'(sat32(rnd_shift14(ue), sat));
        vm = (mag64(ve) + 64'sd8192) >>> 14;
        if (vm == 0)
            f = 0;
        else
        begin
            fm = damper_power(vm);
            if (fm > (64'd1 << 33))
                fm = 64'd1 << 33;
            f = ve < 0 ? -longint'(fm) : longint'(fm);
        end
        f = sat32(f, sat);
        o.fax = 32'(f);
        o.f_ix = 32'(sat32(rnd_shift14(-px * f), sat));
        o.f_iz = 32'(sat32(rnd_shift14(-pz * f), sat));
        o.f_jx = 32'(sat32(rnd_shift14(px * f), sat));
        o.f_jz = 32'(sat32(rnd_shift14(pz * f), sat));
        o.sat = sat;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40)
            $display("ERROR response %0d: %s got %h expected %h",
                     response_count, what, got, want);
    endtask

    // Driver: one transaction per accepted start.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            element_t e;
            if (start && !busy)
            begin
                expected_responses.push_back(dashpot_response('{disp_i_x, disp_i_z,
                    disp_j_x, disp_j_z, vel_i_x, vel_i_z, vel_j_x, vel_j_z}));
                element_count++;
            end
            if ((!start || !busy) && pending_elements.size() > 0 && !hold_off
                && $urandom_range(99) >= idle_pct)
            begin
                e = pending_elements.pop_front();
                start <= 1'b1;
                disp_i_x <= e.ux_i;
                disp_i_z <= e.uz_i;
                disp_j_x <= e.ux_j;
                disp_j_z <= e.uz_j;
                vel_i_x <= e.vx_i;
                vel_i_z <= e.vz_i;
                vel_j_x <= e.vx_j;
                vel_j_z <= e.vz_j;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        response_t w;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                error_count++;
                $display("ERROR unexpected result transaction");
            end
            else
            begin
                w = expected_responses.pop_front();
                if (elongation !== w.elong)
                    report_mismatch("elongation", elongation, w.elong);
                if (axial_force !== w.fax)
                    report_mismatch("axial_force", axial_force, w.fax);
                if (force_i_x !== w.f_ix)
                    report_mismatch("force_i_x", force_i_x, w.f_ix);
                if (force_i_z !== w.f_iz)
                    report_mismatch("force_i_z", force_i_z, w.f_iz);
                if (force_j_x !== w.f_jx)
                    report_mismatch("force_j_x", force_j_x, w.f_jx);
                if (force_j_z !== w.f_jz)
                    report_mismatch("force_j_z", force_j_z, w.f_jz);
                if (saturated !== w.sat)
                    report_mismatch("saturated", 32'(saturated), 32'(w.sat));
                if (w.sat)
                    sat_count++;
                if (w.fax == 0)
                    zero_rate_count++;
            end
            response_count++;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DAMPING: coef_c = val;
            CFG_EXPONENT: coef_alpha = val[15:0];
            CFG_PROJ_X: cos_x = val[15:0];
            default: cos_z = val[15:0];
        endcase
    endtask

    task automatic set_damper(input logic [31:0] c, input logic [15:0] a,
                              input logic signed [15:0] tx, input logic signed [15:0] tz);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_EXPONENT, {16'd0, a});
        write_reg(CFG_PROJ_X, {{16{tx[15]}}, tx});
        write_reg(CFG_PROJ_Z, {{16{tz[15]}}, tz});
    endtask

    // Wait until the pipeline has drained completely.
    task automatic drain;
        @(posedge clk);
        while (pending_elements.size() > 0 || start || expected_responses.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
            2: return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 32'hFFFFFF) - 32'h7FFFFF;
        endcase
    endfunction

    function automatic element_t rand_element;
        element_t e;
        int k;
        k = $urandom_range(0, 3);
        e.ux_i = rand_word(k);
        e.uz_i = rand_word(k);
        e.ux_j = rand_word(k);
        e.uz_j = rand_word(k);
        k = $urandom_range(0, 9);
        e.vx_i = rand_word(k);
        e.vz_i = rand_word(k);
        e.vx_j = rand_word(k);
        e.vz_j = rand_word(k);
        if (k == 9)
        begin
            e.vx_j = e.vx_i;
            e.vz_j = e.vz_i;
        end
        return e;
    endfunction

    task automatic random_batch(input int count);
        repeat (count) pending_elements.push_back(rand_element());
    endtask

    function automatic logic signed [15:0] rand_cos;
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    initial
    begin
        element_t e;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DAMPING;
        cfg_data = '0;
        {disp_i_x, disp_i_z, disp_j_x, disp_j_z} = '0;
        {vel_i_x, vel_i_z, vel_j_x, vel_j_z} = '0;
        coef_c = 0;
        coef_alpha = 16384;
        cos_x = 16384;
        cos_z = 0;
        hold_off = 1'b0;
        idle_pct = 26;
        error_count = 0;
        response_count = 0;
        element_count = 0;
        sat_count = 0;
        zero_rate_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset exponent and projections, then field extremes, zero rate, zero exponent.
        set_damper(32'h0001_0000, 16'd16384, 16'sd16384, 16'sd0);
        e = '{0, 0, 0, 0, 0, 0, 0, 0};
        pending_elements.push_back(e);
        e = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
        pending_elements.push_back(e);
        e = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        pending_elements.push_back(e);
        e = '{32'hFFFFFFFF, 0, 1, 0, 0, 0, 1, 0};
        pending_elements.push_back(e);
        e = '{0, 0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 0};
        pending_elements.push_back(e);
        e = '{0, 0, 0, 0, 0, 0, 32'h30000, 32'h5000};
        pending_elements.push_back(e);
        drain();
        set_damper(32'hFFFFFFFF, 16'd0, -16'sd16384, 16'sd16384);
        e = '{1, 2, 3, 4, 0, 0, 0, 32'h00020000};
        pending_elements.push_back(e);
        e = '{0, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h80000000, 0};
        pending_elements.push_back(e);
        e = '{0, 0, 0, 0, 5, 5, 5, 5};
        pending_elements.push_back(e);
        drain();
        set_damper(32'hFFFFFFFF, 16'd32768, 16'sd11585, -16'sd11585);
        e = '{0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
        pending_elements.push_back(e);
        e = '{0, 0, 0, 0, 0, 0, 32'h1, 0};
        pending_elements.push_back(e);
        e = '{0, 0, 0, 0, 0, 0, 32'h8000, 32'h100};
        pending_elements.push_back(e);
        drain();
        // Out-of-range exponent bits are used as read.
        set_damper(32'h00008000, 16'hFFFF, 16'sh7FFF, 16'sh8000);
        random_batch(8);
        drain();

        // Random phases over several settings and idle profiles.
        for (int ph = 0; ph < 15; ph++)
        begin
            idle_pct = ph < 5 ? 26 : (ph < 10 ? 69 : 0);
            set_damper($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000),
                       $urandom_range(0, 5) == 0 ? 16'(32768 * $urandom_range(0, 1))
                                                 : 16'($urandom_range(0, 32768)),
                       rand_cos(), rand_cos());
            random_batch(25);
            // Hold the sender until every expected result is back.
            wait (pending_elements.size() == 0);
            @(posedge clk);
            hold_off = 1'b1;
            while (start || expected_responses.size() > 0)
                @(posedge clk);
            hold_off = 1'b0;
            random_batch(25);
            drain();
        end

        $display("Covered %0d elements over 19 damper settings and three idle profiles;",
                 element_count);
        $display("%0d results saturated, %0d with zero force.", sat_count, zero_rate_count);
        if (error_count == 0)
            $display("power_law_dashpot_force_core: match");
        else
            $display("power_law_dashpot_force_core: mismatch");
        $finish;
    end

endmodule
